### rtl/core/ultrasonic_echo_ranger_unit_macros.svh
// Assertion macros shared by the ultrasonic echo ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define UERU_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Condition must never be true at a clock edge outside reset.
`define UERU_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define UERU_ASSERT(name, clk, rst_n, prop)
`define UERU_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

### rtl/core/ueru_pkg.sv
// Types and constants of the ultrasonic echo ranger.
package ueru_pkg;

  localparam int unsigned CountW   = 20;
  localparam int unsigned TrigW    = 8;
  localparam int unsigned RiseW    = 20;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned GapW     = 20;
  localparam int unsigned CfgDataW = 20;
  localparam int unsigned PulseW   = 15;
  localparam int unsigned DistW    = 10;

  localparam int unsigned PreLowTicks  = 20;
  localparam int unsigned PostLowTicks = 40;

  // Echo microseconds per centimeter, valid from 32 to 64.
  localparam int unsigned UsPerCm = 58;

  localparam logic [TrigW-1:0]  TrigRst  = 8'd30;
  localparam logic [RiseW-1:0]  RiseRst  = 20'd600000;
  localparam logic [LimitW-1:0] LimitRst = 16'd60000;
  localparam logic [GapW-1:0]   GapRst   = 20'd327680;

  typedef enum logic [2:0] {
    PH_GAP  = 3'd0,
    PH_PRE  = 3'd1,
    PH_TRIG = 3'd2,
    PH_POST = 3'd3,
    PH_WAIT = 3'd4,
    PH_MEAS = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_DIST    = 2'd1,
    ST_NO_OBST = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_TRIGGER = 2'd0,
    CFG_RISE    = 2'd1,
    CFG_LIMIT   = 2'd2,
    CFG_GAP     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic              drive_en;
    logic              drive_lvl;
    status_e           status;
    logic [PulseW-1:0] pulse_us;
  } res_t;

  typedef struct packed {
    res_t             res;
    logic [DistW-1:0] distance_cm;
  } out_t;

endpackage

### rtl/core/ultrasonic_echo_ranger_unit.sv
// Top level of the single-pin ultrasonic echo ranger.
//
//   channel   direction  payload
//   s_axis    in         tdata[0] echo_level, one 0.5 us tick per transaction
//   m_axis    out        tdata pin drive, pulse_us, distance_cm; tuser status
//   cfg       in         cfg_idx_i selects the setting, cfg_data_i its value
//
// Every input transaction yields exactly one output transaction.
// A tick can be taken in every cycle unless the output stalls; its result passes three
// registers (sequencer register, distance stage, output register) on the way out.
// The sequencer state advances only on accepted ticks, so stalls never lose time.
// After reset the block is in the gap phase with the default settings.
`include "ultrasonic_echo_ranger_unit_macros.svh"

module ultrasonic_echo_ranger_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [ueru_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [0] echo_level, [7:1] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] pin_drive_enable, [1] pin_drive_level, [16:2] pulse_us,
  // [26:17] distance_cm, [31:27] zero
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser   // [1:0] status
);
  import ueru_pkg::*;

  res_t res;
  out_t div_out, out;
  logic res_valid, res_ready, div_valid, div_ready;

  ueru_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_e'(cfg_idx_i)),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .echo_i      (s_axis_tdata[0]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ueru_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .res_i       (res),
    .out_valid_o (div_valid),
    .out_ready_i (div_ready),
    .out_o       (div_out)
  );

  ueru_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .in_i        (div_out),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = {5'b0, out.distance_cm, out.res.pulse_us,
                         out.res.drive_lvl, out.res.drive_en};
  assign m_axis_tuser = out.res.status;

  // A measurement result always comes with the pin released.
  `UERU_ASSERT(a_result_released, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tuser != ST_NONE) |-> !m_axis_tdata[0])
  // The pin is only driven high while it is driven.
  `UERU_ASSERT(a_level_needs_drive, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[0])
  // Pulse and distance are zero unless a distance is reported.
  `UERU_ASSERT(a_payload_only_dist, clk_i, rst_ni,
    (m_axis_tvalid && m_axis_tuser != ST_DIST) |-> (m_axis_tdata[26:2] == 25'd0))
  // Input is only held off while a result waits at the output.
  `UERU_ASSERT_NEVER(a_stall_needs_output, clk_i, rst_ni,
    !s_axis_tready && !m_axis_tvalid)

endmodule

### rtl/core/ueru_seq.sv
// Measurement sequencer: phase state, tick counter, settings and the result register.
module ueru_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  ueru_pkg::cfg_idx_e cfg_idx_i,
  input  logic [ueru_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               echo_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output ueru_pkg::res_t     res_o
);
  import ueru_pkg::*;

  logic [TrigW-1:0]  trig_q;
  logic [RiseW-1:0]  rise_q;
  logic [LimitW-1:0] limit_q;
  logic [GapW-1:0]   gap_q;

  phase_e            phase_q, phase_d;
  logic [CountW-1:0] cnt_q, cnt_d, cnt_inc;
  logic              gap_done, accept;
  res_t              res_q, res_d;
  logic              res_valid_q;

  assign cnt_inc    = cnt_q + CountW'(1);
  assign gap_done   = cnt_q >= CountW'(gap_q);
  assign in_ready_o = !res_valid_q || res_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q  <= TrigRst;
      rise_q  <= RiseRst;
      limit_q <= LimitRst;
      gap_q   <= GapRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TRIGGER: trig_q  <= cfg_data_i[TrigW-1:0];
        CFG_RISE:    rise_q  <= cfg_data_i[RiseW-1:0];
        CFG_LIMIT:   limit_q <= cfg_data_i[LimitW-1:0];
        CFG_GAP:     gap_q   <= cfg_data_i[GapW-1:0];
        default:     trig_q  <= trig_q;
      endcase
    end
  end

  // Next phase and tick count for the tick being accepted.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_inc;
    unique case (phase_q)
      PH_PRE: begin
        if (cnt_inc >= CountW'(PreLowTicks)) begin
          phase_d = PH_TRIG;
          cnt_d   = '0;
        end
      end
      PH_TRIG: begin
        if (cnt_inc >= CountW'(trig_q)) begin
          phase_d = PH_POST;
          cnt_d   = '0;
        end
      end
      PH_POST: begin
        if (cnt_inc >= CountW'(PostLowTicks)) begin
          phase_d = PH_WAIT;
          cnt_d   = '0;
        end
      end
      PH_WAIT: begin
        if (echo_i) begin
          phase_d = PH_MEAS;
          cnt_d   = '0;
        end else if (cnt_inc >= CountW'(rise_q)) begin
          phase_d = PH_GAP;
          cnt_d   = '0;
        end
      end
      PH_MEAS: begin
        if (!echo_i || cnt_inc > CountW'(limit_q)) begin
          phase_d = PH_GAP;
          cnt_d   = '0;
        end
      end
      default: begin
        // The gap ends on the tick that finds the count done; that tick is the
        // first pre-low tick.
        if (gap_done) begin
          phase_d = PH_PRE;
          cnt_d   = CountW'(1);
        end else begin
          phase_d = PH_GAP;
        end
      end
    endcase
  end

  // Result of the tick being accepted.
  always_comb begin
    res_d = '{drive_en: 1'b0, drive_lvl: 1'b0, status: ST_NONE, pulse_us: '0};
    unique case (phase_q)
      PH_PRE, PH_POST: res_d.drive_en = 1'b1;
      PH_TRIG: begin
        res_d.drive_en  = 1'b1;
        res_d.drive_lvl = 1'b1;
      end
      PH_WAIT: begin
        if (!echo_i && cnt_inc >= CountW'(rise_q)) res_d.status = ST_TIMEOUT;
      end
      PH_MEAS: begin
        if (!echo_i) begin
          res_d.status   = ST_DIST;
          res_d.pulse_us = cnt_q[PulseW:1];
        end else if (cnt_inc > CountW'(limit_q)) begin
          res_d.status = ST_NO_OBST;
        end
      end
      default: res_d.drive_en = gap_done;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_GAP;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/core/ueru_div.sv
// Distance stage: divides the echo width by the microseconds per centimeter.
module ueru_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ueru_pkg::res_t res_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ueru_pkg::out_t out_o
);
  import ueru_pkg::*;

  // Rounded-up reciprocal; exact for every 15-bit pulse while the divisor is
  // at most 64.
  localparam int unsigned DivShift = PulseW + 6;
  localparam int unsigned ProdW    = PulseW + DivShift;
  localparam logic [DivShift-1:0] RecipK =
    DivShift'(((64'd1 << DivShift) + UsPerCm - 1) / UsPerCm);

  logic [ProdW-1:0] prod;
  logic             valid_q, accept;
  out_t             out_q;

  assign prod       = ProdW'(res_i.pulse_us) * ProdW'(RecipK);
  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.res         <= res_i;
      out_q.distance_cm <= prod[DivShift +: DistW];
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = out_q;

endmodule

### rtl/core/ueru_skid.sv
// Output register with a skid entry, so the upstream ready is a flop.
module ueru_skid (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ueru_pkg::out_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ueru_pkg::out_t out_o
);
  import ueru_pkg::*;

  out_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic out_free;

  assign in_ready_o = !skid_valid_q;
  assign out_free   = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      // The skid entry drains first; upstream is held off while it is full.
      out_valid_q  <= skid_valid_q || in_valid_i;
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : in_i;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_q <= in_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
